### rtl/skva_pkg.sv
// Shared types, codes and helpers for the sparse key/value accumulator.
package skva_pkg;

    // Item kinds
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_GET   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // Multiplicative hash constant (golden ratio)
    localparam logic [31:0] HASH_MULT = 32'h9E3779B1;

    // Saturation limits of a signed Q32.32 sum
    localparam logic [63:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SUM_MIN = 64'h8000_0000_0000_0000;

    // One slot of the hash table
    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [63:0] sum;
    } t_entry;

    // Saturating add result
    typedef struct packed {
        logic [63:0] sum;
        logic        sat;
    } t_sat_res;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_ADDR,
        S_CHECK,
        S_UPDATE,
        S_RESULT
    } t_state;

    // Add two signed 64-bit patterns, clamping to the nearest limit on overflow
    function automatic t_sat_res sat_add(input logic [63:0] a, input logic [63:0] b);
        t_sat_res    res;
        logic [63:0] raw;
        raw     = a + b;
        res.sat = (a[63] == b[63]) && (raw[63] != a[63]);
        if (res.sat) begin
            res.sum = a[63] ? SUM_MIN : SUM_MAX;
        end else begin
            res.sum = raw;
        end
        return res;
    endfunction

endpackage

### rtl/skva_ram.sv
// Single-read, single-write table memory with registered read data.
module skva_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    output skva_pkg::t_entry     o_rd_data,
    input  logic                 i_wr_en,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  skva_pkg::t_entry     i_wr_data
);
    import skva_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered; data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/sparse_key_value_accumulator.sv
// Top level of the sparse key/value accumulator: hashed table with linear probing.
//
//  Channel  Direction  Handshake           Payload
//  input    in         i_valid / o_stall   i_kind, i_key, i_amount
//  output   out        o_valid / i_stall   o_sum_out, o_new_entry, o_status
//
// Add and get pass through the hash, address and check states to their result, with P table
// probes (1 <= P <= CAPACITY); an add that hits its key adds a read-modify-write update state.
// A clear sweeps the table one slot per cycle, then loads its result.
// The next transaction is taken in the idle state that follows a load; after reset the sweep
// clears every slot before the first one.
// A waiting result holds under i_stall while the next transaction runs up to its result state.
module sparse_key_value_accumulator #(
    parameter int CAPACITY = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_key,
    input  logic signed [63:0] i_amount,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [63:0] o_sum_out,
    output logic               o_new_entry,
    output logic [1:0]         o_status
);
    import skva_pkg::*;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // Control state
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic              r_clr_item, n_clr_item;
    logic              r_out_valid, n_out_valid;

    // Payload registers
    logic [1:0]        r_kind, n_kind;
    logic [31:0]       r_key, n_key;
    logic [63:0]       r_amount, n_amount;
    logic [31:0]       r_hash, n_hash;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0]  r_probes, n_probes;
    logic [63:0]       r_res_sum, n_res_sum;
    logic              r_res_new, n_res_new;
    logic [1:0]        r_res_status, n_res_status;
    logic [63:0]       r_out_sum, n_out_sum;
    logic              r_out_new, n_out_new;
    logic [1:0]        r_out_status, n_out_status;

    // Table port signals
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    t_entry            rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_entry            wr_data;

    // Datapath helpers
    logic [31:0]          hash_prod;
    logic [32+CNT_W-1:0]  slot_prod;
    logic [ADDR_W-1:0]    slot_home;
    logic [ADDR_W-1:0]    addr_next;
    logic                 hit;
    logic                 empty;
    logic                 out_free;
    t_sat_res             upd;

    skva_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // Hash the key, then scale the hash into the slot range
    assign hash_prod = r_key * HASH_MULT;
    assign slot_prod = {{CNT_W{1'b0}}, r_hash} * (32 + CNT_W)'(CAPACITY);
    assign slot_home = slot_prod[32 +: ADDR_W];

    // Linear probe step with wrap
    assign addr_next = (r_addr == ADDR_W'(CAPACITY - 1)) ? '0 : r_addr + 1'b1;

    assign hit      = rd_data.valid && (rd_data.key == r_key);
    assign empty    = !rd_data.valid;
    assign out_free = !r_out_valid || !i_stall;
    assign upd      = sat_add(rd_data.sum, r_amount);

    // Next state and table accesses
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_clr_addr   = r_clr_addr;
        n_clr_item   = r_clr_item;
        n_out_valid  = r_out_valid;
        n_kind       = r_kind;
        n_key        = r_key;
        n_amount     = r_amount;
        n_hash       = r_hash;
        n_addr       = r_addr;
        n_probes     = r_probes;
        n_res_sum    = r_res_sum;
        n_res_new    = r_res_new;
        n_res_status = r_res_status;
        n_out_sum    = r_out_sum;
        n_out_new    = r_out_new;
        n_out_status = r_out_status;
        rd_en        = 1'b0;
        rd_addr      = r_addr;
        wr_en        = 1'b0;
        wr_addr      = r_addr;
        wr_data      = '{valid: 1'b1, key: r_key, sum: r_amount};

        // Drop the output once taken
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                // Invalidate one slot per cycle
                wr_en      = 1'b1;
                wr_addr    = r_clr_addr;
                wr_data    = '{valid: 1'b0, key: '0, sum: '0};
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(CAPACITY - 1)) begin
                    n_clr_addr = '0;
                    n_count    = '0;
                    n_clr_item = 1'b0;
                    n_state    = r_clr_item ? S_RESULT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_kind       = i_kind;
                    n_key        = i_key;
                    n_amount     = i_amount;
                    n_res_sum    = '0;
                    n_res_new    = 1'b0;
                    n_res_status = ST_OK;
                    case (i_kind)
                        KIND_ADD, KIND_GET: n_state = S_HASH;
                        KIND_CLEAR: begin
                            n_clr_addr = '0;
                            n_clr_item = 1'b1;
                            n_state    = S_CLEAR;
                        end
                        default: n_state = S_RESULT;
                    endcase
                end
            end
            S_HASH: begin
                n_hash  = hash_prod;
                n_state = S_ADDR;
            end
            S_ADDR: begin
                // Issue the first probe
                rd_en    = 1'b1;
                rd_addr  = slot_home;
                n_addr   = slot_home;
                n_probes = CNT_W'(1);
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                if (hit) begin
                    if (r_kind == KIND_ADD) begin
                        n_state = S_UPDATE;
                    end else begin
                        n_res_sum = rd_data.sum;
                        n_state   = S_RESULT;
                    end
                end else if (empty) begin
                    if (r_kind == KIND_ADD) begin
                        if (r_count < CNT_W'(CAPACITY)) begin
                            // Insert the new key in the free slot
                            wr_en     = 1'b1;
                            n_count   = r_count + 1'b1;
                            n_res_sum = r_amount;
                            n_res_new = 1'b1;
                        end else begin
                            n_res_status = ST_FULL;
                        end
                    end
                    n_state = S_RESULT;
                end else if (r_probes == CNT_W'(CAPACITY)) begin
                    // Every slot probed: key absent, table full
                    if (r_kind == KIND_ADD) begin
                        n_res_status = ST_FULL;
                    end
                    n_state = S_RESULT;
                end else begin
                    // Advance to the next slot
                    rd_en    = 1'b1;
                    rd_addr  = addr_next;
                    n_addr   = addr_next;
                    n_probes = r_probes + 1'b1;
                end
            end
            S_UPDATE: begin
                // Write back the accumulated sum
                wr_en        = 1'b1;
                wr_data      = '{valid: 1'b1, key: r_key, sum: upd.sum};
                n_res_sum    = upd.sum;
                n_res_status = upd.sat ? ST_SAT : ST_OK;
                n_state      = S_RESULT;
            end
            S_RESULT: begin
                // Hold until the output register frees
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sum    = r_res_sum;
                    n_out_new    = r_res_new;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_count     <= '0;
            r_clr_addr  <= '0;
            r_clr_item  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_clr_addr  <= n_clr_addr;
            r_clr_item  <= n_clr_item;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_key        <= n_key;
        r_amount     <= n_amount;
        r_hash       <= n_hash;
        r_addr       <= n_addr;
        r_probes     <= n_probes;
        r_res_sum    <= n_res_sum;
        r_res_new    <= n_res_new;
        r_res_status <= n_res_status;
        r_out_sum    <= n_out_sum;
        r_out_new    <= n_out_new;
        r_out_status <= n_out_status;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_sum_out   = r_out_sum;
    assign o_new_entry = r_out_new;
    assign o_status    = r_out_status;

    // The entry count never exceeds the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // An insert during a probe bumps the count by one
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && wr_en) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not advance entry count");

    // A new result only comes out of the result state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || !i_stall) ##1 r_out_valid |-> $past(r_state) == S_RESULT)
        else $error("output loaded outside result state");

    // Probing never walks past the whole table
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_probes <= CNT_W'(CAPACITY)))
        else $error("probe count above capacity");

    // A new entry flag is reported only with ok status
    a_new_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_new) |-> (r_out_status == ST_OK))
        else $error("new entry with error status");

endmodule
